// File: rtl/ea_adpcm_stereo_decoder_defines.svh
// Assertion macros shared by the EA ADPCM stereo decoder RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef EA_ADPCM_STEREO_DECODER_DEFINES_SVH
`define EA_ADPCM_STEREO_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EAAD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EAAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/eaad_pkg.sv
// Package for the EA ADPCM stereo decoder: command type, queue sizing,
// coefficient table and the per-channel predictor. No dependencies.
`default_nettype none

package eaad_pkg;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Rounding term added before the final shift by 8
  localparam logic signed [27:0] ROUND_BIAS = 28'sd128;
  localparam logic signed [19:0] PCM_MAX = 20'sd32767;
  localparam logic signed [19:0] PCM_MIN = -20'sd32768;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  // One queue entry: a chunk start (history) or a sample byte with its context
  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [15:0] left_newest;
    logic signed [15:0] left_older;
    logic signed [15:0] right_newest;
    logic signed [15:0] right_older;
    logic [7:0]         sample_byte;
    logic [3:0]         coef_left;
    logic [3:0]         coef_right;
    logic [3:0]         scale_left;
    logic [3:0]         scale_right;
    logic               last;
  } cmd_t;

  // Predictor coefficients: c1 at n, c2 at n + 4
  function automatic logic signed [9:0] coef_lookup(input logic [4:0] idx);
    logic signed [9:0] c;
    case (idx)
      5'd1:    c = 10'sd240;
      5'd2:    c = 10'sd460;
      5'd3:    c = 10'sd392;
      5'd6:    c = -10'sd208;
      5'd7:    c = -10'sd220;
      5'd9:    c = 10'sd1;
      5'd10:   c = 10'sd3;
      5'd11:   c = 10'sd4;
      5'd12:   c = 10'sd7;
      5'd13:   c = 10'sd8;
      5'd14:   c = 10'sd10;
      5'd15:   c = 10'sd11;
      5'd17:   c = -10'sd1;
      5'd18:   c = -10'sd3;
      5'd19:   c = -10'sd4;
      default: c = 10'sd0;
    endcase
    return c;
  endfunction

  // Predict one channel and clip to 16 bits
  function automatic logic signed [15:0] predict(
    input logic [3:0]         nib,
    input logic [3:0]         sel,
    input logic [3:0]         shn,
    input logic signed [15:0] newest,
    input logic signed [15:0] older
  );
    logic signed [23:0] d;
    logic signed [9:0]  c1;
    logic signed [9:0]  c2;
    logic signed [25:0] p1;
    logic signed [25:0] p2;
    logic signed [27:0] sum;
    logic signed [19:0] q;
    logic signed [15:0] res;
    // nibble << 28 then >> (shn + 8) is nibble * 2^(20 - shn)
    d   = $signed({nib, 20'b0}) >>> shn;
    c1  = coef_lookup({1'b0, sel});
    c2  = coef_lookup({1'b0, sel} + 5'd4);
    p1  = 26'(newest) * 26'(c1);
    p2  = 26'(older) * 26'(c2);
    sum = 28'(d) + 28'(p1) + 28'(p2) + ROUND_BIAS;
    q   = 20'(sum >>> 8);
    if (q > PCM_MAX) begin
      res = 16'sh7FFF;
    end else if (q < PCM_MIN) begin
      res = 16'sh8000;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/eaad_front.sv
// Front end: accepts stream bytes, tracks chunk count and subblock position,
// holds coefficient and shift selectors, and queues commands. Uses eaad_pkg.
`default_nettype none

`include "ea_adpcm_stereo_decoder_defines.svh"

module eaad_front
  import eaad_pkg::*;
#(
  parameter int SAMPLES_PER_SUBBLOCK = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] sample_count,
  input  wire logic [15:0] left_current,
  input  wire logic [15:0] left_previous,
  input  wire logic [15:0] right_current,
  input  wire logic [15:0] right_previous,
  output logic             push,
  output cmd_t             push_cmd,
  input  wire logic        full
);

  localparam logic [4:0] LAST_POS = 5'(SAMPLES_PER_SUBBLOCK + 1);

  logic [15:0] samples_remaining;
  logic [4:0]  subblock_position;
  logic [3:0]  coef_select_left;
  logic [3:0]  coef_select_right;
  logic [3:0]  shift_nibble_left;
  logic [3:0]  shift_nibble_right;
  logic        xfer;
  logic        is_sample;
  logic        count_last;

  assign in_ready   = !full;
  assign xfer       = in_valid && in_ready;
  assign count_last = (samples_remaining == 16'd1);
  assign is_sample  = action && (samples_remaining != 16'd0) &&
                      (subblock_position != 5'd0) && (subblock_position != 5'd1);

  // Build the queue entry for a start or a sample byte
  always_comb begin
    push_cmd = '0;
    push     = 1'b0;
    if (xfer && !action) begin
      push                  = 1'b1;
      push_cmd.kind         = CMD_START;
      push_cmd.left_newest  = left_current;
      push_cmd.left_older   = left_previous;
      push_cmd.right_newest = right_current;
      push_cmd.right_older  = right_previous;
    end else if (xfer && is_sample) begin
      push                 = 1'b1;
      push_cmd.kind        = CMD_SAMPLE;
      push_cmd.sample_byte = data_byte;
      push_cmd.coef_left   = coef_select_left;
      push_cmd.coef_right  = coef_select_right;
      push_cmd.scale_left  = shift_nibble_left;
      push_cmd.scale_right = shift_nibble_right;
      push_cmd.last        = count_last;
    end
  end

  // Advance count, position and selectors on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_remaining  <= '0;
      subblock_position  <= '0;
      coef_select_left   <= '0;
      coef_select_right  <= '0;
      shift_nibble_left  <= '0;
      shift_nibble_right <= '0;
    end else if (xfer) begin
      if (!action) begin
        samples_remaining <= sample_count;
        subblock_position <= '0;
      end else if (samples_remaining != 16'd0) begin
        if (subblock_position == 5'd0) begin
          coef_select_left  <= data_byte[7:4];
          coef_select_right <= data_byte[3:0];
          subblock_position <= 5'd1;
        end else if (subblock_position == 5'd1) begin
          shift_nibble_left  <= data_byte[7:4];
          shift_nibble_right <= data_byte[3:0];
          subblock_position  <= 5'd2;
        end else begin
          samples_remaining <= samples_remaining - 16'd1;
          if (subblock_position >= LAST_POS || count_last) begin
            subblock_position <= '0;
          end else begin
            subblock_position <= subblock_position + 5'd1;
          end
        end
      end
    end
  end

  `EAAD_ASSERT_SAME(a_sample_needs_count, push && push_cmd.kind == CMD_SAMPLE, samples_remaining != 16'd0, "sample queued with no samples remaining")

endmodule

`default_nettype wire

// File: rtl/eaad_fifo.sv
// Short command queue between front and back ends; register storage.
// Uses eaad_pkg for the entry type and depth.
`default_nettype none

`include "ea_adpcm_stereo_decoder_defines.svh"

module eaad_fifo
  import eaad_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full       = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  // Write entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `EAAD_ASSERT_SAME(a_no_push_full, push, !full, "push into a full queue")
  `EAAD_ASSERT_SAME(a_no_pop_empty, pop, head_valid, "pop from an empty queue")

endmodule

`default_nettype wire

// File: rtl/eaad_back.sv
// Back end: holds channel history, runs both predictors on each sample entry
// and drives the registered output stage. Uses eaad_pkg.
`default_nettype none

`include "ea_adpcm_stereo_decoder_defines.svh"

module eaad_back
  import eaad_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [15:0] left_sample,
  output logic [15:0] right_sample,
  output logic       last_of_chunk
);

  logic signed [15:0] left_newest;
  logic signed [15:0] left_older;
  logic signed [15:0] right_newest;
  logic signed [15:0] right_older;
  logic signed [15:0] left_next;
  logic signed [15:0] right_next;
  logic               slot_free;
  logic               take_sample;

  assign slot_free   = !out_valid || out_ready;
  assign take_sample = head_valid && (head_cmd.kind == CMD_SAMPLE) && slot_free;
  assign pop         = (head_valid && (head_cmd.kind == CMD_START)) || take_sample;

  assign left_next  = predict(head_cmd.sample_byte[7:4], head_cmd.coef_left,
                              head_cmd.scale_left, left_newest, left_older);
  assign right_next = predict(head_cmd.sample_byte[3:0], head_cmd.coef_right,
                              head_cmd.scale_right, right_newest, right_older);

  // Load or move history
  always_ff @(posedge clk) begin
    if (rst) begin
      left_newest  <= '0;
      left_older   <= '0;
      right_newest <= '0;
      right_older  <= '0;
    end else if (head_valid && head_cmd.kind == CMD_START) begin
      left_newest  <= head_cmd.left_newest;
      left_older   <= head_cmd.left_older;
      right_newest <= head_cmd.right_newest;
      right_older  <= head_cmd.right_older;
    end else if (take_sample) begin
      left_older   <= left_newest;
      left_newest  <= left_next;
      right_older  <= right_newest;
      right_newest <= right_next;
    end
  end

  // Output stage: fill on a sample, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      left_sample   <= left_next;
      right_sample  <= right_next;
      last_of_chunk <= head_cmd.last;
    end
  end

  `EAAD_ASSERT_NEXT(a_hist_follows_out, take_sample, out_valid && left_newest == $signed(left_sample) && right_newest == $signed(right_sample), "history and output disagree")

endmodule

`default_nettype wire

// File: rtl/ea_adpcm_stereo_decoder.sv
// EA ADPCM stereo chunk decoder: top level joining front end, command queue
// and back end. Depends on eaad_pkg, eaad_front, eaad_fifo and eaad_back.
//
// Use: send a start transfer (tuser = 0) with the stereo sample count and the
// two history samples per channel, then the chunk bytes (tuser = 1): per
// subblock one coefficient byte, one shift byte and up to
// SAMPLES_PER_SUBBLOCK sample bytes. Each sample byte gives one output
// transfer carrying left and right samples; tlast marks the final sample of
// the chunk. Bytes past the end of the count, and bytes before any start, are
// dropped. A start in mid-chunk abandons the running chunk.
// Path: a taken sample byte is written into the queue and leaves it through
// the predictor into the output register. Throughput: one input byte per
// cycle unless the queue is full, one sample per cycle unless the receiver
// stalls; the history update (two 16x10 multiplies, sum, clip) is combinational.
// Reset clears history, selectors, count and queue; the block then drops data
// bytes until a start arrives. When the receiver stalls, the output register
// holds and the four-entry queue absorbs further work before s_axis_tready
// falls.
`default_nettype none

module ea_adpcm_stereo_decoder
  import eaad_pkg::*;
#(
  parameter int SAMPLES_PER_SUBBLOCK = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [23:8] sample_count, [39:24] left_current,
  // [55:40] left_previous, [71:56] right_current, [87:72] right_previous
  input  wire logic [87:0] s_axis_tdata,
  // [0] action
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] left_sample, [31:16] right_sample
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  eaad_front #(
    .SAMPLES_PER_SUBBLOCK(SAMPLES_PER_SUBBLOCK)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .action         (s_axis_tuser),
    .data_byte      (s_axis_tdata[7:0]),
    .sample_count   (s_axis_tdata[23:8]),
    .left_current   (s_axis_tdata[39:24]),
    .left_previous  (s_axis_tdata[55:40]),
    .right_current  (s_axis_tdata[71:56]),
    .right_previous (s_axis_tdata[87:72]),
    .push           (push),
    .push_cmd       (push_cmd),
    .full           (full)
  );

  eaad_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  eaad_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .left_sample   (m_axis_tdata[15:0]),
    .right_sample  (m_axis_tdata[31:16]),
    .last_of_chunk (m_axis_tlast)
  );

endmodule

`default_nettype wire
